// ----- design/zdop_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the signature matcher for the zip directory offset patcher
// no dependencies

package zdop_pkg;

    // input and output beats
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] patched_byte;
        logic       end_of_file;
        logic [1:0] outcome;
    } out_t;

    // work the back part does on one byte
    typedef enum logic [1:0] {
        OP_PASS      = 2'd0,
        OP_ADD_FIRST = 2'd1,
        OP_ADD_NEXT  = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] data;
        op_t        op;
        logic [1:0] lane;
        logic       final_byte;
        logic [1:0] outcome;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam int QUEUE_DEPTH = 4;

    // central directory entry layout
    localparam logic [17:0] CEN_FIXED_LEN      = 18'd46;
    localparam logic [17:0] CEN_NAME_LEN_AT    = 18'd28;
    localparam logic [17:0] CEN_EXTRA_LEN_AT   = 18'd30;
    localparam logic [17:0] CEN_COMMENT_LEN_AT = 18'd32;
    localparam logic [17:0] CEN_LOCAL_OFF_AT   = 18'd42;
    localparam logic [17:0] CEN_SIG_LEN        = 18'd3;

    // end record layout
    localparam logic [4:0]  END_DIR_OFF_AT     = 5'd16;
    localparam logic [4:0]  END_SIG_LEN        = 5'd3;

    // signature bytes
    localparam logic [7:0] SIG_BYTE_P    = 8'h50;
    localparam logic [7:0] SIG_BYTE_K    = 8'h4B;
    localparam logic [7:0] SIG_BYTE_DIR0 = 8'h01;
    localparam logic [7:0] SIG_BYTE_DIR1 = 8'h02;
    localparam logic [7:0] SIG_BYTE_END0 = 8'h05;
    localparam logic [7:0] SIG_BYTE_END1 = 8'h06;

    // matched prefix of a signature
    localparam logic [2:0] SIG_NONE = 3'd0;
    localparam logic [2:0] SIG_P    = 3'd1;
    localparam logic [2:0] SIG_PK   = 3'd2;
    localparam logic [2:0] SIG_PK01 = 3'd3;
    localparam logic [2:0] SIG_PK05 = 3'd4;

    // file status and outcome codes
    localparam logic [1:0] STATUS_PENDING = 2'd0;
    localparam logic [1:0] STATUS_PATCHED = 2'd1;
    localparam logic [1:0] STATUS_EARLY   = 2'd2;

    localparam logic [1:0] OUTCOME_PATCHED = 2'd0;
    localparam logic [1:0] OUTCOME_NO_END  = 2'd1;
    localparam logic [1:0] OUTCOME_EARLY   = 2'd2;

    typedef enum logic [1:0] {
        HIT_NONE = 2'd0,
        HIT_DIR  = 2'd1,
        HIT_END  = 2'd2
    } hit_t;

    typedef struct packed {
        logic [2:0] progress;
        hit_t       hit;
    } match_t;

    // one step of the shared matcher for the directory and end signatures
    function automatic match_t match_step(input logic [2:0] progress, input logic [7:0] b);
        match_t m;
        m.progress = (b == SIG_BYTE_P) ? SIG_P : SIG_NONE;
        m.hit      = HIT_NONE;
        if (progress == SIG_P && b == SIG_BYTE_K) begin
            m.progress = SIG_PK;
        end else if (progress == SIG_PK && b == SIG_BYTE_DIR0) begin
            m.progress = SIG_PK01;
        end else if (progress == SIG_PK && b == SIG_BYTE_END0) begin
            m.progress = SIG_PK05;
        end else if (progress == SIG_PK01 && b == SIG_BYTE_DIR1) begin
            m.progress = SIG_NONE;
            m.hit      = HIT_DIR;
        end else if (progress == SIG_PK05 && b == SIG_BYTE_END1) begin
            m.progress = SIG_NONE;
            m.hit      = HIT_END;
        end
        return m;
    endfunction

endpackage

// ----- design/zdop_front.sv -----
`timescale 1ns / 1ps
// front part: parses the byte stream and tags each byte with the patch work it needs
// depends on zdop_pkg

module zdop_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  zdop_pkg::in_t   beat,
    output zdop_pkg::item_t item
);

    typedef enum logic [6:0] {
        PH_SEARCH   = 7'b0000001,
        PH_ENTRY    = 7'b0000010,
        PH_NEXT     = 7'b0000100,
        PH_SEEK_END = 7'b0001000,
        PH_END      = 7'b0010000,
        PH_DONE     = 7'b0100000,
        PH_EARLY    = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [2:0]  sig_reg, sig_next;
    logic [17:0] entry_idx_reg, entry_idx_next;
    logic [17:0] len_sum_reg, len_sum_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [31:0] dir_start_reg, dir_start_next;
    logic [4:0]  end_idx_reg, end_idx_next;
    logic [1:0]  status_reg, status_next;

    zdop_pkg::match_t m;
    logic [7:0]  b;
    logic [17:0] idx_inc;
    logic [17:0] off_diff;
    logic [4:0]  end_inc;
    logic [4:0]  end_diff;
    logic [18:0] entry_last;

    always_comb
    begin
        b              = beat.data_byte;
        m              = zdop_pkg::match_step(sig_reg, b);
        idx_inc        = entry_idx_reg + 18'd1;
        off_diff       = idx_inc - zdop_pkg::CEN_LOCAL_OFF_AT;
        end_inc        = end_idx_reg + 5'd1;
        end_diff       = end_inc - zdop_pkg::END_DIR_OFF_AT;
        entry_last     = 19'd0;

        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg + 32'd1;
        sig_next       = sig_reg;
        entry_idx_next = entry_idx_reg;
        len_sum_next   = len_sum_reg;
        len_low_next   = len_low_reg;
        dir_start_next = dir_start_reg;
        end_idx_next   = end_idx_reg;
        status_next    = status_reg;

        item.data       = b;
        item.op         = zdop_pkg::OP_PASS;
        item.lane       = 2'd0;
        item.final_byte = beat.final_byte;
        item.outcome    = zdop_pkg::OUTCOME_PATCHED;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                sig_next = m.progress;
                if (m.hit == zdop_pkg::HIT_DIR) begin
                    dir_start_next = byte_pos_reg - 32'd3;
                    phase_next     = PH_ENTRY;
                    entry_idx_next = zdop_pkg::CEN_SIG_LEN;
                    len_sum_next   = 18'd0;
                    len_low_next   = 8'd0;
                end else if (m.hit == zdop_pkg::HIT_END) begin
                    phase_next  = PH_EARLY;
                    status_next = zdop_pkg::STATUS_EARLY;
                end
            end
            PH_ENTRY:
            begin
                entry_idx_next = idx_inc;
                if (idx_inc == zdop_pkg::CEN_NAME_LEN_AT ||
                    idx_inc == zdop_pkg::CEN_EXTRA_LEN_AT ||
                    idx_inc == zdop_pkg::CEN_COMMENT_LEN_AT) begin
                    len_low_next = b;
                end else if (idx_inc == zdop_pkg::CEN_NAME_LEN_AT + 18'd1 ||
                             idx_inc == zdop_pkg::CEN_EXTRA_LEN_AT + 18'd1 ||
                             idx_inc == zdop_pkg::CEN_COMMENT_LEN_AT + 18'd1) begin
                    len_sum_next = len_sum_reg + {2'b00, b, len_low_reg};
                end else if (off_diff < 18'd4) begin
                    item.op   = (off_diff[1:0] == 2'd0) ? zdop_pkg::OP_ADD_FIRST
                                                        : zdop_pkg::OP_ADD_NEXT;
                    item.lane = off_diff[1:0];
                end
                // entry ends after its fixed part plus the three variable fields
                entry_last = {1'b0, zdop_pkg::CEN_FIXED_LEN - 18'd1} + {1'b0, len_sum_next};
                if (idx_inc >= zdop_pkg::CEN_FIXED_LEN - 18'd1 &&
                    {1'b0, idx_inc} == entry_last) begin
                    phase_next = PH_NEXT;
                    sig_next   = zdop_pkg::SIG_NONE;
                end
            end
            PH_NEXT:
            begin
                sig_next = m.progress;
                if (m.hit == zdop_pkg::HIT_DIR) begin
                    phase_next     = PH_ENTRY;
                    entry_idx_next = zdop_pkg::CEN_SIG_LEN;
                    len_sum_next   = 18'd0;
                    len_low_next   = 8'd0;
                end else if (m.hit == zdop_pkg::HIT_END) begin
                    phase_next   = PH_END;
                    end_idx_next = zdop_pkg::END_SIG_LEN;
                    status_next  = zdop_pkg::STATUS_PATCHED;
                end else if (m.progress <= sig_reg) begin
                    // chain broken, keep looking for the end record from here
                    phase_next = PH_SEEK_END;
                end
            end
            PH_SEEK_END:
            begin
                sig_next = m.progress;
                if (m.hit == zdop_pkg::HIT_END) begin
                    phase_next   = PH_END;
                    end_idx_next = zdop_pkg::END_SIG_LEN;
                    status_next  = zdop_pkg::STATUS_PATCHED;
                end
            end
            PH_END:
            begin
                end_idx_next = end_inc;
                if (end_diff < 5'd4) begin
                    // directory start goes through the same byte adder as the offsets
                    item.data = dir_start_reg[{end_diff[1:0], 3'b000} +: 8];
                    item.op   = (end_diff[1:0] == 2'd0) ? zdop_pkg::OP_ADD_FIRST
                                                        : zdop_pkg::OP_ADD_NEXT;
                    item.lane = end_diff[1:0];
                end
                if (end_inc >= zdop_pkg::END_DIR_OFF_AT + 5'd3) begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE, PH_EARLY:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        // status includes a signature completed by this very beat
        if (beat.final_byte) begin
            case (status_next)
                zdop_pkg::STATUS_PATCHED: item.outcome = zdop_pkg::OUTCOME_PATCHED;
                zdop_pkg::STATUS_EARLY:   item.outcome = zdop_pkg::OUTCOME_EARLY;
                default:                  item.outcome = zdop_pkg::OUTCOME_NO_END;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_SEARCH;
            byte_pos_reg  <= 32'd0;
            sig_reg       <= zdop_pkg::SIG_NONE;
            entry_idx_reg <= 18'd0;
            len_sum_reg   <= 18'd0;
            len_low_reg   <= 8'd0;
            dir_start_reg <= 32'd0;
            end_idx_reg   <= 5'd0;
            status_reg    <= zdop_pkg::STATUS_PENDING;
        end else if (accept) begin
            if (beat.final_byte) begin
                // last beat of a file, start the next one clean
                phase_reg     <= PH_SEARCH;
                byte_pos_reg  <= 32'd0;
                sig_reg       <= zdop_pkg::SIG_NONE;
                entry_idx_reg <= 18'd0;
                len_sum_reg   <= 18'd0;
                len_low_reg   <= 8'd0;
                dir_start_reg <= 32'd0;
                end_idx_reg   <= 5'd0;
                status_reg    <= zdop_pkg::STATUS_PENDING;
            end else begin
                phase_reg     <= phase_next;
                byte_pos_reg  <= byte_pos_next;
                sig_reg       <= sig_next;
                entry_idx_reg <= entry_idx_next;
                len_sum_reg   <= len_sum_next;
                len_low_reg   <= len_low_next;
                dir_start_reg <= dir_start_next;
                end_idx_reg   <= end_idx_next;
                status_reg    <= status_next;
            end
        end
    end

endmodule

// ----- design/zdop_queue.sv -----
`timescale 1ns / 1ps
// short fifo of tagged beats between the front and back parts
// depends on zdop_pkg

module zdop_queue #(
    parameter int DEPTH = zdop_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  zdop_pkg::item_t         push_item,
    input  logic                    pop,
    output zdop_pkg::item_t         head_item,
    output zdop_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zdop_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
        status.full  = (count_reg == CNT_W'(DEPTH));
        status.empty = (count_reg == '0);
        head_item    = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/zdop_back.sv -----
`timescale 1ns / 1ps
// back part: byte adder with carry for offset fields, and the registered output beat
// depends on zdop_pkg

module zdop_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     shift_amount,
    input  logic            item_valid,
    input  zdop_pkg::item_t item,
    output logic            item_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output zdop_pkg::out_t  out_data
);

    logic           valid_reg, valid_next;
    logic           carry_reg, carry_next;
    zdop_pkg::out_t data_reg, data_next;
    logic [7:0]     shift_byte;
    logic           carry_in;
    logic [8:0]     sum;

    always_comb
    begin
        item_pop   = item_valid && (!valid_reg || !out_stall);
        shift_byte = shift_amount[{item.lane, 3'b000} +: 8];
        carry_in   = (item.op == zdop_pkg::OP_ADD_NEXT) ? carry_reg : 1'b0;
        sum        = {1'b0, item.data} + {1'b0, shift_byte} + {8'd0, carry_in};

        carry_next = carry_reg;
        data_next  = data_reg;
        valid_next = valid_reg && out_stall;
        if (item_pop) begin
            valid_next             = 1'b1;
            data_next.end_of_file  = item.final_byte;
            data_next.outcome      = item.outcome;
            data_next.patched_byte = item.data;
            if (item.op == zdop_pkg::OP_ADD_FIRST || item.op == zdop_pkg::OP_ADD_NEXT) begin
                data_next.patched_byte = sum[7:0];
                carry_next             = sum[8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            carry_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/zip_directory_offset_patcher_core.sv -----
`timescale 1ns / 1ps
// top level of the zip directory offset patcher: front parser, beat queue, back adder
// depends on zdop_pkg, zdop_front, zdop_queue, zdop_back
//
//  channel   handshake               payload
//  in        in_valid / in_stall     in_data  (data_byte, final_byte)
//  out       out_valid / out_stall   out_data (patched_byte, end_of_file, outcome)
//  config    cfg_wr_en               cfg_wr_data (shift_amount)
//
// one beat per cycle in and out while in_stall and out_stall are low; with the queue empty, a byte
// taken in is written to a queue slot, then popped into the output register and leaves from there.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full, so the front keeps
// taking beats while the output side is stalled, until QUEUE_DEPTH + 1 beats are held.
// reset clears the parse state and shift_amount; the parse state also clears after
// each beat marked final_byte.

module zip_directory_offset_patcher_core #(
    parameter int QUEUE_DEPTH = zdop_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  zdop_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output zdop_pkg::out_t out_data,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data
);

    logic [31:0] shift_amount_reg;
    logic                    in_accept;
    logic                    q_pop;
    zdop_pkg::item_t         front_item;
    zdop_pkg::item_t         head_item;
    zdop_pkg::queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shift_amount_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            shift_amount_reg <= cfg_wr_data;
        end
    end

    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !q_status.full;

    zdop_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .beat   (in_data),
        .item   (front_item)
    );

    zdop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    zdop_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift_amount (shift_amount_reg),
        .item_valid   (!q_status.empty),
        .item         (head_item),
        .item_pop     (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    // status only rides on the last beat of a file
    a_outcome_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_file |-> out_data.outcome == zdop_pkg::OUTCOME_PATCHED)
        else $error("outcome set on a beat that is not the last of its file");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.outcome <= zdop_pkg::OUTCOME_EARLY)
        else $error("undefined outcome code");

    // a new output beat must come from a queued beat
    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_status.empty))
        else $error("output beat without a queued beat");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !q_status.empty)
        else $error("queue reports full and empty together");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("back part popped an empty queue");

endmodule

// ----- sim/tb_zip_directory_offset_patcher_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for zip_directory_offset_patcher_core: directed beats, then random
// zip-like files under several shift settings, scored against an in-bench predictor
// depends on zdop_pkg and the core rtl

module tb_zip_directory_offset_patcher_core;
    import zdop_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int unsigned PHASE_BYTES = 190;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OUTCOME_NONE = 2'd0;

    typedef enum logic [2:0] {
        SCAN_DIR,
        IN_ENTRY,
        AT_BOUNDARY,
        SCAN_END,
        IN_END_REC,
        FILE_DONE,
        EARLY_PASS
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] outcome;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // predictor state
    logic [31:0]  shift_amt;
    logic [31:0]  byte_pos;
    logic [31:0]  dir_start;
    parse_phase_t parse_ph;
    logic [2:0]   sig_prog;
    logic [17:0]  ent_idx;
    logic [17:0]  len_sum;
    logic [7:0]   len_lo;
    logic         carry;
    logic [4:0]   end_idx;
    logic [1:0]   file_status;

    out_t        pending_bytes[$];
    logic [7:0]  archive[$];
    out_t        head_result;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_sent = 0;
    int unsigned files_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_in = 0;
    int unsigned quiet_out = 0;
    int unsigned stall_left = 0;
    bit          drained_mid_file = 1'b0;

    // short files: single bytes, early end record, partial signatures, cut entry
    dir_row_t directed_rows [0:24] = '{
        '{8'h00, 1'b1, 1'b1, OUTCOME_NO_END},
        '{8'hFF, 1'b1, 1'b1, OUTCOME_NO_END},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h4B, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h05, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h06, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h4B, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h01, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h02, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'hAA, 1'b1, 1'b1, OUTCOME_EARLY},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h4B, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h05, 1'b1, 1'b1, OUTCOME_NO_END},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h4B, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h01, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h02, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h7F, 1'b0, 1'b0, OUTCOME_NONE},
        '{8'h80, 1'b1, 1'b1, OUTCOME_NO_END},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h50, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h4B, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h05, 1'b0, 1'b1, OUTCOME_NONE},
        '{8'h06, 1'b1, 1'b1, OUTCOME_EARLY}
    };

    zip_directory_offset_patcher_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycle_count, pending_bytes.size());
            $display("** zip_directory_offset_patcher_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_parse();
        byte_pos    = '0;
        dir_start   = '0;
        parse_ph    = SCAN_DIR;
        sig_prog    = SIG_NONE;
        ent_idx     = '0;
        len_sum     = '0;
        len_lo      = '0;
        carry       = 1'b0;
        end_idx     = '0;
        file_status = STATUS_PENDING;
    endfunction

    function automatic hit_t advance_signature(input logic [7:0] d);
        logic [2:0] nxt;
        hit_t       found;
        nxt = (d == SIG_BYTE_P) ? SIG_P : SIG_NONE;
        found = HIT_NONE;
        case (sig_prog)
            SIG_P:
                if (d == SIG_BYTE_K)
                    nxt = SIG_PK;
            SIG_PK:
            begin
                if (d == SIG_BYTE_DIR0)
                    nxt = SIG_PK01;
                else if (d == SIG_BYTE_END0)
                    nxt = SIG_PK05;
            end
            SIG_PK01:
                if (d == SIG_BYTE_DIR1)
                begin
                    nxt = SIG_NONE;
                    found = HIT_DIR;
                end
            SIG_PK05:
                if (d == SIG_BYTE_END1)
                begin
                    nxt = SIG_NONE;
                    found = HIT_END;
                end
            default: ;
        endcase
        sig_prog = nxt;
        return found;
    endfunction

    function automatic void open_entry();
        parse_ph = IN_ENTRY;
        ent_idx  = CEN_SIG_LEN;
        len_sum  = '0;
        len_lo   = '0;
        carry    = 1'b0;
    endfunction

    function automatic void open_end_record();
        parse_ph    = IN_END_REC;
        end_idx     = END_SIG_LEN;
        file_status = STATUS_PATCHED;
    endfunction

    function automatic out_t predict_patched(input in_t beat);
        out_t        r;
        hit_t        found;
        logic [7:0]  d;
        logic [2:0]  prev;
        logic [17:0] ent_off;
        logic [4:0]  end_off;
        logic [1:0]  lane;
        logic [8:0]  sum9;
        logic [31:0] moved_start;
        d = beat.data_byte;
        r.patched_byte = d;
        r.end_of_file  = beat.final_byte;
        r.outcome      = OUTCOME_NONE;
        case (parse_ph)
            SCAN_DIR:
            begin
                found = advance_signature(d);
                if (found == HIT_DIR)
                begin
                    dir_start = byte_pos - 32'd3;
                    open_entry();
                end
                else if (found == HIT_END)
                begin
                    parse_ph = EARLY_PASS;
                    file_status = STATUS_EARLY;
                end
            end
            IN_ENTRY:
            begin
                ent_idx = ent_idx + 18'd1;
                if (ent_idx == CEN_NAME_LEN_AT || ent_idx == CEN_EXTRA_LEN_AT ||
                    ent_idx == CEN_COMMENT_LEN_AT)
                    len_lo = d;
                else if (ent_idx == CEN_NAME_LEN_AT + 18'd1 || ent_idx == CEN_EXTRA_LEN_AT + 18'd1 ||
                         ent_idx == CEN_COMMENT_LEN_AT + 18'd1)
                    len_sum = len_sum + {2'b00, d, len_lo};
                else if (ent_idx >= CEN_LOCAL_OFF_AT && ent_idx < CEN_LOCAL_OFF_AT + 18'd4)
                begin
                    // byte-wise add, carry only chains from the previous lane
                    ent_off = ent_idx - CEN_LOCAL_OFF_AT;
                    lane = ent_off[1:0];
                    sum9 = {1'b0, d} + {1'b0, shift_amt[8 * lane +: 8]} +
                           ((lane == 2'd0) ? 9'd0 : {8'd0, carry});
                    r.patched_byte = sum9[7:0];
                    carry = sum9[8];
                end
                if (ent_idx >= CEN_FIXED_LEN - 18'd1 && ent_idx == CEN_FIXED_LEN - 18'd1 + len_sum)
                begin
                    parse_ph = AT_BOUNDARY;
                    sig_prog = SIG_NONE;
                end
            end
            AT_BOUNDARY:
            begin
                prev = sig_prog;
                found = advance_signature(d);
                if (found == HIT_DIR)
                    open_entry();
                else if (found == HIT_END)
                    open_end_record();
                else if (sig_prog <= prev)
                    parse_ph = SCAN_END;
            end
            SCAN_END:
            begin
                found = advance_signature(d);
                if (found == HIT_END)
                    open_end_record();
            end
            IN_END_REC:
            begin
                end_idx = end_idx + 5'd1;
                if (end_idx >= END_DIR_OFF_AT && end_idx < END_DIR_OFF_AT + 5'd4)
                begin
                    moved_start = dir_start + shift_amt;
                    end_off = end_idx - END_DIR_OFF_AT;
                    lane = end_off[1:0];
                    r.patched_byte = moved_start[8 * lane +: 8];
                end
                if (end_idx >= END_DIR_OFF_AT + 5'd3)
                    parse_ph = FILE_DONE;
            end
            default: ;
        endcase
        byte_pos = byte_pos + 32'd1;
        if (beat.final_byte)
        begin
            if (file_status == STATUS_PATCHED)
                r.outcome = OUTCOME_PATCHED;
            else if (file_status == STATUS_EARLY)
                r.outcome = OUTCOME_EARLY;
            else
                r.outcome = OUTCOME_NO_END;
            clear_parse();
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    task automatic flag_result(input string what, input out_t want, input out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s: expected byte %02h eof %0b outcome %0d, got byte %02h eof %0b outcome %0d",
                     what, want.patched_byte, want.end_of_file, want.outcome,
                     got.patched_byte, got.end_of_file, got.outcome);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                flag_result("result beat with nothing pending", '0, out_data);
            else
            begin
                head_result = pending_bytes.pop_front();
                results_checked++;
                if (out_data.patched_byte !== head_result.patched_byte ||
                    out_data.end_of_file !== head_result.end_of_file ||
                    out_data.outcome !== head_result.outcome)
                    flag_result("result mismatch", head_result, out_data);
            end
        end
    end

    // ---------------------------------------------------------------- idling

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // output side: random stalls with occasional quiet stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            if (quiet_out == 0 && $urandom_range(99) < 2)
                quiet_out = $urandom_range(30, 150);
            if (quiet_out != 0)
                quiet_out--;
            else
                stall_left = gap_len();
        end
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input in_t beat, input bit typed, input out_t typed_result);
        int unsigned gap;
        out_t        pred;
        gap = 0;
        if (quiet_in != 0)
            quiet_in--;
        else if ($urandom_range(99) < 2)
            quiet_in = $urandom_range(30, 150);
        else
            gap = gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_patched(beat);
        pending_bytes.push_back(typed ? typed_result : pred);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_shift(input logic [31:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shift_amt = value;
        settings_used++;
    endtask

    // ---------------------------------------------------------------- file builder

    // bias toward signature bytes so partial and false matches show up often
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return SIG_BYTE_P;
            1: return SIG_BYTE_K;
            2: return SIG_BYTE_DIR0;
            3: return SIG_BYTE_DIR1;
            4: return SIG_BYTE_END0;
            default: return SIG_BYTE_END1;
        endcase
    endfunction

    function automatic logic [7:0] offset_byte();
        case ($urandom_range(3))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 8);
        if (r < 98)
            return $urandom_range(9, 40);
        return $urandom_range(256, 700);
    endfunction

    task automatic add_signature(input bit is_end);
        archive.push_back(SIG_BYTE_P);
        archive.push_back(SIG_BYTE_K);
        archive.push_back(is_end ? SIG_BYTE_END0 : SIG_BYTE_DIR0);
        archive.push_back(is_end ? SIG_BYTE_END1 : SIG_BYTE_DIR1);
    endtask

    task automatic add_le16(input logic [15:0] v);
        archive.push_back(v[7:0]);
        archive.push_back(v[15:8]);
    endtask

    // filler, sometimes with a whole signature buried in it
    task automatic add_body(input int unsigned count);
        int unsigned x;
        int unsigned at;
        bit          embed;
        embed = count >= 4 && $urandom_range(4) == 0;
        at = embed ? $urandom_range(0, count - 4) : 0;
        x = 0;
        while (x < count)
        begin
            if (embed && x == at)
            begin
                add_signature($urandom_range(1));
                x += 4;
            end
            else
            begin
                archive.push_back(noise_byte());
                x++;
            end
        end
    endtask

    task automatic add_entry(input bit huge);
        int unsigned name_len;
        int unsigned extra_len;
        int unsigned comment_len;
        name_len    = huge ? 32'hFFFF : pick_len();
        extra_len   = pick_len();
        comment_len = pick_len();
        add_signature(1'b0);
        repeat (24) archive.push_back(noise_byte());
        add_le16(name_len[15:0]);
        add_le16(extra_len[15:0]);
        add_le16(comment_len[15:0]);
        repeat (8) archive.push_back(noise_byte());
        repeat (4) archive.push_back(offset_byte());
        add_body(name_len + extra_len + comment_len);
    endtask

    task automatic add_end_record();
        int unsigned note_len;
        note_len = $urandom_range(0, 5);
        add_signature(1'b1);
        repeat (12) archive.push_back(noise_byte());
        repeat (4) archive.push_back(offset_byte());
        add_le16(note_len[15:0]);
        add_body(note_len);
    endtask

    task automatic build_archive(input bit huge);
        int unsigned n_ent;
        int unsigned e;
        int unsigned keep;
        archive.delete();
        add_body($urandom_range(0, 12));
        if ($urandom_range(9) == 0)
            add_end_record();
        if ($urandom_range(14) != 0)
        begin
            n_ent = $urandom_range(1, 4);
            for (e = 0; e < n_ent; e++)
            begin
                add_entry(huge && e == 0);
                // junk between entries breaks the chain
                if ($urandom_range(9) == 0)
                    add_body($urandom_range(1, 6));
            end
        end
        if ($urandom_range(9) != 0)
        begin
            if ($urandom_range(3) == 0)
                add_body($urandom_range(1, 8));
            add_end_record();
            if ($urandom_range(7) == 0)
                add_end_record();
        end
        add_body($urandom_range(0, 4));
        if (!huge && archive.size() > 1 && $urandom_range(9) == 0)
        begin
            keep = $urandom_range(1, archive.size() - 1);
            while (archive.size() > keep)
                void'(archive.pop_back());
        end
        if (archive.size() == 0)
            archive.push_back(noise_byte());
    endtask

    task automatic send_archive();
        int unsigned i;
        for (i = 0; i < archive.size(); i++)
        begin
            // let the output drain completely in the middle of a file now and then
            if ((!drained_mid_file && archive.size() > 8 && i == archive.size() / 2) ||
                $urandom_range(499) == 0)
            begin
                wait_drained();
                drained_mid_file = 1'b1;
            end
            send_byte({archive[i], i == archive.size() - 1}, 1'b0, '0);
        end
        files_sent++;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int          row;
        int unsigned phase_idx;
        int unsigned phase_start;
        logic [31:0] shift_value;

        shift_amt = '0;
        clear_parse();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shift stays at its reset value here
        for (row = 0; row < 25; row++)
            send_byte({directed_rows[row].data, directed_rows[row].last},
                      directed_rows[row].typed,
                      {directed_rows[row].data, directed_rows[row].last,
                       directed_rows[row].outcome});
        files_sent += 6;

        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            case (phase_idx)
                0: shift_value = 32'hFFFF_FFFF;
                1: shift_value = 32'h0000_0000;
                2: shift_value = 32'h0000_0001;
                3: shift_value = 32'h8000_0000;
                default: shift_value = $urandom();
            endcase
            write_shift(shift_value);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_archive(1'b0);
                // cut the file short where it would overrun this phase
                while (archive.size() > PHASE_BYTES - (bytes_sent - phase_start))
                    void'(archive.pop_back());
                send_archive();
            end
        end

        wait_drained();

        $display("checked %0d result beats from %0d files (%0d bytes) under %0d shift settings",
                 results_checked, files_sent, bytes_sent, settings_used);
        $display("offset patching, chained and broken directories, early/missing/cut end records:"
                 , " %0d failures", fail_count);
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("** zip_directory_offset_patcher_core: PASSED **");
        else
            $display("** zip_directory_offset_patcher_core: FAILED **");
        $finish;
    end

endmodule
